// File: hw/rtl/tgle_pkg.sv
`default_nettype none

package tgle_pkg;

   localparam int TagW    = 4;
   localparam int HandleW = 32;
   localparam int CountW  = 5;
   localparam int CmdW    = 3;

   typedef enum logic [CmdW-1:0] {
      CMD_APPEND  = 3'd0,
      CMD_TINSERT = 3'd1,
      CMD_POP     = 3'd2,
      CMD_TPOP    = 3'd3,
      CMD_COUNT   = 3'd4,
      CMD_TCOUNT  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_NOTAG = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [TagW-1:0]    tag;
      logic [HandleW-1:0] handle;
   } entry_type;

   typedef struct packed {
      status_type         status;
      logic [TagW-1:0]    tag;
      logic [HandleW-1:0] handle;
      logic [CountW-1:0]  count;
   } res_type;

endpackage

`default_nettype wire

// File: hw/rtl/tgle_ram.sv
`default_nettype none

module tgle_ram
   import tgle_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/typed_grouped_list_engine_top.sv
// Typed grouped list engine: an ordered list of up to DEPTH (tag, handle) entries
// held in a single-port-read, single-port-write RAM.
// Request channel (req_*): cmd, type_tag, data_handle, one transaction per command.
// Response channel (rsp_*): status, out_tag, out_handle, out_count, exactly one
// transaction per request, in request order.
// Sequence: append, count and refused commands go from accept to the result stage
// and then to the response register; pop of the tail first reads and captures the
// last entry. Typed commands scan the list one RAM read per cycle, then move
// entries one per cycle; the single RAM read port sets this pace.
// One command is in flight at a time; the next request is taken as soon as the
// previous result has moved into the response register, even if it is not taken.
// Reset clears the fill level and both valid flags; the list is empty afterwards
// and no RAM clearing pass is needed.
// When the receiver stalls, the response register holds and a finished command
// waits in its result stage, so at most one further request is taken.
`default_nettype none

module typed_grouped_list_engine_top
   import tgle_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CmdW-1:0]    req_cmd,
   input  wire logic [TagW-1:0]    req_type_tag,
   input  wire logic [HandleW-1:0] req_data_handle,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [TagW-1:0]         rsp_out_tag,
   output logic [HandleW-1:0]      rsp_out_handle,
   output logic [CountW-1:0]       rsp_out_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [TagW-1:0]     tag_ff, tag_in;
   logic [HandleW-1:0]  handle_ff, handle_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       sh_ff, sh_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic                found_ff, found_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                up_ff, up_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   res_type             res_ff, res_in;
   res_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   entry_type           mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;
   entry_type           mem_rdata;

   logic                req_fire;
   logic                is_full;
   logic                is_empty;
   logic [CW-1:0]       ins_pos;

   tgle_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign is_full   = (fill_ff == CW'(DEPTH));
   assign is_empty  = (fill_ff == '0);
   assign ins_pos   = found_ff ? (CW'(pos_ff) + CW'(1)) : fill_ff;

   // next state, datapath and RAM control
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      tag_in       = tag_ff;
      handle_in    = handle_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      sh_in        = sh_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      up_in        = up_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '{tag: tag_ff, handle: handle_ff};
      mem_re       = 1'b0;
      mem_raddr    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in    = cmd_type'(req_cmd);
               tag_in    = req_type_tag;
               handle_in = req_data_handle;
               idx_in    = '0;
               found_in  = 1'b0;
               cnt_in    = '0;
               res_in    = '{status: ST_OK, tag: '0, handle: '0, count: '0};
               state_in  = S_RESP;
               unique case (cmd_type'(req_cmd))
                  CMD_APPEND: begin
                     if (is_full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(fill_ff);
                        mem_wdata = '{tag: req_type_tag, handle: req_data_handle};
                        fill_in   = fill_ff + CW'(1);
                     end
                  end
                  CMD_TINSERT: begin
                     if (is_full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_POP: begin
                     if (is_empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        pos_in   = AW'(fill_ff - CW'(1));
                        sh_in    = fill_ff - CW'(1);
                        up_in    = 1'b0;
                        state_in = S_SHIFT;
                     end
                  end
                  CMD_TPOP, CMD_TCOUNT: begin
                     if (is_empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_COUNT: begin
                     if (is_empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        res_in.count = CountW'(fill_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            // compare the entry read last cycle
            if (rd_pend_ff && (mem_rdata.tag == tag_ff)) begin
               found_in = 1'b1;
               pos_in   = rd_idx_ff;
               cnt_in   = cnt_ff + CW'(1);
            end
            // issue the next read, or close the scan
            if (idx_ff < fill_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = AW'(idx_ff);
               rd_pend_in = 1'b1;
               rd_idx_in  = AW'(idx_ff);
               idx_in     = idx_ff + CW'(1);
            end else if (!rd_pend_ff) begin
               unique case (cmd_ff)
                  CMD_TINSERT: begin
                     pos_in   = AW'(ins_pos);
                     sh_in    = fill_ff;
                     up_in    = 1'b1;
                     state_in = S_SHIFT;
                  end
                  CMD_TPOP: begin
                     if (found_ff) begin
                        sh_in    = CW'(pos_ff);
                        up_in    = 1'b0;
                        state_in = S_SHIFT;
                     end else begin
                        res_in.status = ST_NOTAG;
                        state_in      = S_RESP;
                     end
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        res_in.status = ST_NOTAG;
                     end else begin
                        res_in.count = CountW'(cnt_ff);
                     end
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            if (up_ff) begin
               // move entries one place toward the tail, last one first
               if (rd_pend_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = rd_idx_ff + AW'(1);
                  mem_wdata = mem_rdata;
               end
               if (sh_ff > CW'(pos_ff)) begin
                  mem_re     = 1'b1;
                  mem_raddr  = AW'(sh_ff - CW'(1));
                  rd_pend_in = 1'b1;
                  rd_idx_in  = AW'(sh_ff - CW'(1));
                  sh_in      = sh_ff - CW'(1);
               end else if (!rd_pend_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_ff;
                  fill_in   = fill_ff + CW'(1);
                  state_in  = S_RESP;
               end
            end else begin
               // capture the removed entry, then close the gap
               if (rd_pend_ff) begin
                  if (rd_idx_ff == pos_ff) begin
                     res_in.tag    = mem_rdata.tag;
                     res_in.handle = mem_rdata.handle;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = rd_idx_ff - AW'(1);
                     mem_wdata = mem_rdata;
                  end
               end
               if (sh_ff < fill_ff) begin
                  mem_re     = 1'b1;
                  mem_raddr  = AW'(sh_ff);
                  rd_pend_in = 1'b1;
                  rd_idx_in  = AW'(sh_ff);
                  sh_in      = sh_ff + CW'(1);
               end else if (!rd_pend_ff) begin
                  fill_in  = fill_ff - CW'(1);
                  state_in = S_RESP;
               end
            end
         end

         S_RESP: begin
            // hand the result over once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      tag_ff    <= tag_in;
      handle_ff <= handle_in;
      idx_ff    <= idx_in;
      sh_ff     <= sh_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
      cnt_ff    <= cnt_in;
      up_ff     <= up_in;
      rd_idx_ff <= rd_idx_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_out_tag    = rsp_ff.tag;
   assign rsp_out_handle = rsp_ff.handle;
   assign rsp_out_count  = rsp_ff.count;

   // fill level never passes the capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill level beyond capacity");

   // a shift never reads the entry it writes in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("RAM read and write hit the same entry");

   // a completed removal shrinks the list by exactly one
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && !up_ff && state_in == S_RESP)
         |=> (fill_ff == $past(fill_ff) - CW'(1)))
      else $error("removal did not shrink the list by one");

   // an accepted transaction always leaves idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("engine stayed idle after accepting a transaction");

endmodule

`default_nettype wire
